// ----- sv/base64_decoder_validating_assert.svh -----
// assertion macros for the validating base-64 decoder
// used by the queue and the top level; each macro expects clk and rst_n in scope
`ifndef BASE64_DECODER_VALIDATING_ASSERT_SVH
`define BASE64_DECODER_VALIDATING_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define B64DV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64dv assertion failed");
// next-cycle implication
`define B64DV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64dv assertion failed");
`else
`define B64DV_ASSERT_NOW(label, ante, cons)
`define B64DV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/b64dv_pkg.sv -----
// types and constants of the validating base-64 decoder
// no dependencies; used by the step logic, the result queue and the top level
package b64dv_pkg;

    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2b;
    localparam logic [7:0] CHR_SLASH   = 8'h2f;
    localparam logic [7:0] CHR_PAD     = 8'h3d;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [1:0] MAX_PADS = 2'd2;
    localparam logic [1:0] GROUP_LAST = 2'd3;

    // decoder state carried from item to item
    typedef struct packed {
        logic [17:0] accum;
        logic [1:0]  pos;
        logic [1:0]  pads;
        logic        err;
    } state_t;

    // all results caused by one item: nbytes data bytes, then the closing result if closing is set
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            closing;
        logic            bad;
    } bundle_t;

endpackage

// ----- sv/b64dv_in_if.sv -----
// character channel of the base-64 decoder: valid/ready with one character
// no dependencies
interface b64dv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       final_char;

    modport source (output valid, char_in, final_char, input ready);
    modport sink (input valid, char_in, final_char, output ready);
endinterface

// ----- sv/b64dv_out_if.sv -----
// result channel of the base-64 decoder: valid/ready with one result
// no dependencies
interface b64dv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_out;
    logic       bad_input;

    modport source (output valid, data_byte, byte_valid, last_out, bad_input, input ready);
    modport sink (input valid, data_byte, byte_valid, last_out, bad_input, output ready);
endinterface

// ----- sv/b64dv_step.sv -----
// per-character decode step: sextet lookup, validity checks, group assembly
// depends on b64dv_pkg
module b64dv_step
    import b64dv_pkg::*;
(
    input  logic [7:0] char_in,
    input  logic       final_char,
    input  state_t     state,
    output state_t     state_next,
    output bundle_t    bundle
);

    // returns {legal, sextet}; pad maps to zero
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            t = c - CHR_UPPER_A;
            return {1'b1, t[5:0]};
        end
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            t = c - CHR_LOWER_A + LOWER_BASE;
            return {1'b1, t[5:0]};
        end
        if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            t = c - CHR_DIGIT_0 + DIGIT_BASE;
            return {1'b1, t[5:0]};
        end
        if (c == CHR_PLUS) begin
            return {1'b1, SEXTET_PLUS};
        end
        if (c == CHR_SLASH) begin
            return {1'b1, SEXTET_SLASH};
        end
        if (c == CHR_PAD) begin
            return {1'b1, 6'd0};
        end
        return {1'b0, t[5:0]};
    endfunction

    logic [6:0]  lookup;
    logic        legal;
    logic [5:0]  sextet;
    logic        is_pad;
    logic        err_now;
    logic        take;
    logic [23:0] full;

    assign lookup = char_to_sextet(char_in);
    assign legal  = lookup[6];
    assign sextet = lookup[5:0];
    assign is_pad = (char_in == CHR_PAD);
    assign full   = {state.accum, sextet};

    assign err_now = !state.err
                   && (!legal
                       || (!is_pad && state.pads != 2'd0)
                       || (is_pad && state.pads >= MAX_PADS));
    assign take = !state.err && !err_now;

    always_comb
    begin
        state_next     = state;
        bundle         = '0;
        state_next.err = state.err | err_now;
        if (take)
        begin
            if (is_pad)
            begin
                state_next.pads = state.pads + 2'd1;
            end
            if (state.pos != GROUP_LAST)
            begin
                state_next.accum = full[17:0];
                state_next.pos   = state.pos + 2'd1;
            end
            else
            begin
                // group complete: three bytes less one per pad
                bundle.bytes[0]  = full[23:16];
                bundle.bytes[1]  = full[15:8];
                bundle.bytes[2]  = full[7:0];
                bundle.nbytes    = GROUP_LAST - state_next.pads;
                state_next.accum = '0;
                state_next.pos   = 2'd0;
            end
        end
        if (final_char)
        begin
            bundle.closing = 1'b1;
            bundle.bad     = state_next.err | (state_next.pos != 2'd0);
            state_next     = '0;
        end
    end

endmodule

// ----- sv/b64dv_outq.sv -----
// two-entry result queue: holds results of up to two items, hands them out
// one per cycle while results.ready is high; depends on b64dv_pkg and b64dv_out_if
module b64dv_outq
    import b64dv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bundle_t            push_item,
    output logic               space,
    b64dv_out_if.source        results
);

`include "base64_decoder_validating_assert.svh"

    bundle_t    slot_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] idx_reg;
    bundle_t    head;
    logic [1:0] last_idx;
    logic       pop;
    logic       take;

    assign head  = slot_reg[head_reg];
    assign space = (count_reg != 2'd2);

    // closing result sits right after the data bytes
    assign last_idx = head.closing ? head.nbytes : head.nbytes - 2'd1;

    assign results.valid = (count_reg != 2'd0);
    assign take = results.valid && results.ready;
    assign pop  = take && (idx_reg == last_idx);

    always_comb
    begin
        if (idx_reg < head.nbytes)
        begin
            results.data_byte  = head.bytes[idx_reg];
            results.byte_valid = 1'b1;
            results.last_out   = 1'b0;
            results.bad_input  = 1'b0;
        end
        else
        begin
            results.data_byte  = 8'd0;
            results.byte_valid = 1'b0;
            results.last_out   = 1'b1;
            results.bad_input  = head.bad;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= ~tail_reg;
            end
            if (pop)
            begin
                head_reg <= ~head_reg;
                idx_reg  <= 2'd0;
            end
            else if (take)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_item;
        end
    end

    `B64DV_ASSERT_NOW(a_no_push_when_full, push, count_reg != 2'd2)
    `B64DV_ASSERT_NOW(a_idx_in_range, results.valid, idx_reg <= last_idx)
    `B64DV_ASSERT_NOW(a_count_bound, 1'b1, count_reg != 2'd3)
    `B64DV_ASSERT_NOW(a_ptr_match, count_reg == 2'd0 || count_reg == 2'd2, head_reg == tail_reg)

endmodule

// ----- sv/base64_decoder_validating.sv -----
// top level of the validating base-64 decoder
// depends on b64dv_pkg, b64dv_in_if, b64dv_out_if, b64dv_step and b64dv_outq
//
// char_stream carries one character a item with final_char on the last one
// of a text. byte_stream carries results: decoded bytes with byte_valid = 1,
// and after the final character one closing result with last_out = 1 and
// bad_input telling whether the whole text was valid. Bytes already sent
// for a text whose closing result shows bad_input must be dropped.
// A character is decoded in the cycle it is accepted and its results are
// registered in the result queue. A finished group of four gives up to three
// bytes, handed out one per cycle from a two-entry result queue, so one
// character per cycle is taken while the receiver keeps up (four
// characters give at most three bytes plus the closing result).
// char_stream.ready drops only when the queue holds results of two items;
// when the receiver stalls, results wait in the queue and the input backs
// up once two items that gave results are waiting; until then characters
// that give no result are still taken. Reset clears the decoder state and
// the queue; the first character after reset or after a final character starts a text.
module base64_decoder_validating
    import b64dv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64dv_in_if.sink     char_stream,
    b64dv_out_if.source  byte_stream
);

`include "base64_decoder_validating_assert.svh"

    state_t  state_reg;
    state_t  state_next;
    bundle_t bundle;
    logic    accept;
    logic    push;
    logic    space;

    b64dv_step u_step (
        .char_in    (char_stream.char_in),
        .final_char (char_stream.final_char),
        .state      (state_reg),
        .state_next (state_next),
        .bundle     (bundle)
    );

    assign char_stream.ready = space;
    assign accept = char_stream.valid && char_stream.ready;
    // items that yield nothing never enter the queue
    assign push = accept && (bundle.nbytes != 2'd0 || bundle.closing);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    b64dv_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (bundle),
        .space     (space),
        .results   (byte_stream)
    );

    `B64DV_ASSERT_NEXT(a_final_clears, accept && char_stream.final_char, state_reg == '0)
    `B64DV_ASSERT_NEXT(a_group_restarts, accept && bundle.nbytes != 2'd0, state_reg.pos == 2'd0)
    `B64DV_ASSERT_NOW(a_no_data_after_err, accept && state_reg.err, bundle.nbytes == 2'd0)
    `B64DV_ASSERT_NOW(a_pads_bound, 1'b1, state_reg.pads != 2'd3)

endmodule

// ----- tb/base64_decoder_validating_tb.sv -----
// self-checking testbench for the validating base-64 decoder
// needs b64dv_pkg, b64dv_in_if, b64dv_out_if and base64_decoder_validating
// a directed table of short texts is followed by random texts, all checked
// against a behavioral decoder in this file; typed rows give the expected error flag
module base64_decoder_validating_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64dv_pkg::*;

    localparam int TOTAL_CHARS = 460;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED = 25;

    // one character of stimulus; typed rows carry the expected error flag
    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
        logic       typed;
        logic       typed_bad;
    } char_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        logic       bad;
    } result_t;

    localparam char_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // two data bytes, one pad
        '{"T", 1'b0, 1'b0, 1'b0}, '{"W", 1'b0, 1'b0, 1'b0},
        '{"E", 1'b0, 1'b0, 1'b0}, '{CHR_PAD, 1'b1, 1'b1, 1'b0},
        // one byte, two pads, nonzero leftover bits
        '{"T", 1'b0, 1'b0, 1'b0}, '{"R", 1'b0, 1'b0, 1'b0},
        '{CHR_PAD, 1'b0, 1'b0, 1'b0}, '{CHR_PAD, 1'b1, 1'b1, 1'b0},
        // data after a pad
        '{"A", 1'b0, 1'b0, 1'b0}, '{"B", 1'b0, 1'b0, 1'b0},
        '{CHR_PAD, 1'b0, 1'b0, 1'b0}, '{"C", 1'b1, 1'b1, 1'b1},
        // third pad
        '{"A", 1'b0, 1'b0, 1'b0}, '{CHR_PAD, 1'b0, 1'b0, 1'b0},
        '{CHR_PAD, 1'b0, 1'b0, 1'b0}, '{CHR_PAD, 1'b1, 1'b1, 1'b1},
        // short text
        '{"A", 1'b0, 1'b0, 1'b0}, '{"B", 1'b1, 1'b1, 1'b1},
        // nul, then a good character that must be ignored
        '{8'h00, 1'b0, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b1},
        // top code alone
        '{8'hff, 1'b1, 1'b1, 1'b1},
        // alphabet extremes in one full group
        '{CHR_PLUS, 1'b0, 1'b0, 1'b0}, '{CHR_SLASH, 1'b0, 1'b0, 1'b0},
        '{"z", 1'b0, 1'b0, 1'b0}, '{"9", 1'b1, 1'b1, 1'b0}
    };

    logic clk;
    logic rst_n;

    b64dv_in_if  char_if ();
    b64dv_out_if byte_if ();

    base64_decoder_validating u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .byte_stream (byte_if)
    );

    // decoder state mirrored by the predictor
    logic [17:0] accum;
    logic [1:0]  group_pos;
    logic [1:0]  pads_seen;
    logic        err_seen;

    result_t   awaited_results[$];
    char_row_t char_plan[$];

    int fails;
    int send_idle;
    int recv_idle;
    int stall_cycles;
    int n_texts;
    int n_bytes;
    int n_closing;
    int n_bad_texts;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // returns {known, sextet}; the pad maps to zero
    function automatic logic [6:0] lookup_sextet(input logic [7:0] c);
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z)
            return {1'b1, 6'(c - CHR_UPPER_A)};
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
            return {1'b1, 6'(c - CHR_LOWER_A + LOWER_BASE)};
        if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9)
            return {1'b1, 6'(c - CHR_DIGIT_0 + DIGIT_BASE)};
        if (c == CHR_PLUS)
            return {1'b1, SEXTET_PLUS};
        if (c == CHR_SLASH)
            return {1'b1, SEXTET_SLASH};
        if (c == CHR_PAD)
            return {1'b1, 6'd0};
        return 7'd0;
    endfunction

    function automatic logic [7:0] alphabet_char(input int idx);
        if (idx < 26)
            return CHR_UPPER_A + 8'(idx);
        if (idx < 52)
            return CHR_LOWER_A + 8'(idx - 26);
        if (idx < 62)
            return CHR_DIGIT_0 + 8'(idx - 52);
        if (idx == 62)
            return CHR_PLUS;
        return CHR_SLASH;
    endfunction

    task automatic clear_decoder();
        accum = '0;
        group_pos = '0;
        pads_seen = '0;
        err_seen = 1'b0;
    endtask

    // advance the mirrored decoder by one character and queue what it gives
    task automatic decode_char(input char_row_t row);
        logic [6:0]  look;
        logic        is_pad;
        logic [23:0] full;
        int          nbytes;
        look = lookup_sextet(row.chr);
        is_pad = (row.chr == CHR_PAD);
        if (!err_seen)
        begin
            if (!look[6])
                err_seen = 1'b1;
            else if (!is_pad && pads_seen != 0)
                err_seen = 1'b1;
            else if (is_pad && pads_seen >= MAX_PADS)
                err_seen = 1'b1;
            else
            begin
                if (is_pad)
                    pads_seen = pads_seen + 2'd1;
                full = {accum, look[5:0]};
                if (group_pos != GROUP_LAST)
                begin
                    accum = full[17:0];
                    group_pos = group_pos + 2'd1;
                end
                else
                begin
                    nbytes = 3 - int'(pads_seen);
                    for (int k = 0; k < nbytes; k++)
                        awaited_results.push_back('{full[23 - 8 * k -: 8], 1'b1, 1'b0, 1'b0});
                    accum = '0;
                    group_pos = '0;
                end
            end
        end
        if (row.fin)
        begin
            if (group_pos != 0)
                err_seen = 1'b1;
            awaited_results.push_back('{8'd0, 1'b0, 1'b1,
                                        row.typed ? row.typed_bad : err_seen});
            clear_decoder();
        end
    endtask

    task automatic flag_mismatch(input string what, input result_t got, input result_t want);
        fails++;
        $display("mismatch: %s: got byte %02h valid %0b last %0b bad %0b, want %02h %0b %0b %0b",
                 what, got.data, got.byte_valid, got.last, got.bad,
                 want.data, want.byte_valid, want.last, want.bad);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            flag_mismatch("result with nothing awaited", got, '0);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                got.last !== want.last || got.bad !== want.bad)
                flag_mismatch("wrong field", got, want);
            if (want.byte_valid)
                n_bytes++;
            if (want.last)
            begin
                n_closing++;
                if (want.bad)
                    n_bad_texts++;
            end
        end
    endtask

    // one random text: mostly well-formed, some corrupted, some noise
    task automatic plan_text();
        logic [7:0] txt[$];
        int         kind;
        int         ngroups;
        int         npads;
        int         len;
        kind = $urandom_range(0, 9);
        if (kind <= 7)
        begin
            ngroups = $urandom_range(1, 3);
            npads = $urandom_range(0, 2);
            for (int g = 0; g < ngroups; g++)
                for (int p = 0; p < 4; p++)
                    if (g == ngroups - 1 && p >= 4 - npads)
                        txt.push_back(CHR_PAD);
                    else
                        txt.push_back(alphabet_char($urandom_range(0, 63)));
            if (kind >= 6)
            begin
                case ($urandom_range(0, 2))
                    0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                    1: repeat ($urandom_range(1, 3))
                           if (txt.size() > 1)
                               void'(txt.pop_back());
                    default: txt[$urandom_range(0, txt.size() - 1)] = CHR_PAD;
                endcase
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                if (kind == 8)
                    txt.push_back(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 4) == 0)
                    txt.push_back(CHR_PAD);
                else
                    txt.push_back(alphabet_char($urandom_range(0, 63)));
        end
        foreach (txt[i])
            char_plan.push_back('{txt[i], i == txt.size() - 1, 1'b0, 1'b0});
    endtask

    // results: ready rolls every cycle, handshake sampled at the falling edge
    initial
    begin
        result_t seen;
        logic    took;
        took = 1'b0;
        seen = '0;
        byte_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (took)
                check_result(seen);
            byte_if.ready <= ($urandom_range(0, 99) >= recv_idle);
            @(negedge clk);
            took = byte_if.valid && byte_if.ready;
            seen = '{byte_if.data_byte, byte_if.byte_valid, byte_if.last_out, byte_if.bad_input};
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(negedge clk)
    begin
        if ((char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic took;
        int   phase;
        rst_n = 1'b0;
        char_if.valid = 1'b0;
        char_if.char_in = '0;
        char_if.final_char = 1'b0;
        fails = 0;
        stall_cycles = 0;
        n_texts = 0;
        n_bytes = 0;
        n_closing = 0;
        n_bad_texts = 0;
        send_idle = 31;
        recv_idle = 75;
        clear_decoder();

        for (int i = 0; i < N_DIRECTED; i++)
            char_plan.push_back(DIRECTED_ROWS[i]);
        while (char_plan.size() < TOTAL_CHARS)
            plan_text();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (char_plan[i])
        begin
            phase = i * 3 / char_plan.size();
            send_idle = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
            recv_idle = (phase == 0) ? 75 : (phase == 1) ? 31 : 0;
            while ($urandom_range(0, 99) < send_idle)
            begin
                char_if.valid <= 1'b0;
                @(posedge clk);
            end
            char_if.valid <= 1'b1;
            char_if.char_in <= char_plan[i].chr;
            char_if.final_char <= char_plan[i].fin;
            do
            begin
                @(negedge clk);
                took = char_if.ready;
                @(posedge clk);
            end while (!took);
            decode_char(char_plan[i]);
            if (char_plan[i].fin)
                n_texts++;
        end
        char_if.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d texts under three idling mixes",
                 char_plan.size(), n_texts);
        $display("checked %0d bytes and %0d closing results, %0d of them flagged invalid",
                 n_bytes, n_closing, n_bad_texts);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
